/* src/ihq_pkg.sv */
// shared types and constants of the indexed min-heap queue
`default_nettype none
package ihq_pkg;

  localparam int DEPTH_DEF    = 1024;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_BITS      = 10;
  localparam int KEY_IN_BITS  = 32;
  localparam int CAP_BITS     = 11;
  localparam int PADDR_BITS   = 3;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_INCREASE = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4,
    ST_LOWER  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH_CHK,
    S_UP,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DOWN,
    S_DOWN_L,
    S_DOWN_R,
    S_INC_POS,
    S_INC_KEY,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t                  action;
    logic [ID_BITS-1:0]       item_id;
    logic [KEY_IN_BITS-1:0]   new_key;
  } cmd_word_t;

  typedef struct packed {
    status_t                  status;
    logic [ID_BITS-1:0]       popped_id;
    logic [KEY_IN_BITS-1:0]   popped_key;
    logic [CAP_BITS-1:0]      entry_count;
  } res_word_t;

endpackage
`default_nettype wire

/* src/ihq_ram.sv */
// single-port-write, single-port-read synchronous memory with registered read
`default_nettype none
module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int ADDRS = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(ADDRS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(ADDRS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [ADDRS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/ihq_ctrl.sv */
// sequencer for push, pop and key increase with hole-based sifting
`default_nettype none
module ihq_ctrl #(
  parameter int DEPTH    = ihq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ihq_pkg::KEY_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [ihq_pkg::CAP_BITS-1:0]           capacity,
  input  logic                                   cmd_valid,
  output logic                                   cmd_stall,
  input  ihq_pkg::cmd_word_t                     cmd,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output ihq_pkg::res_word_t                     res,
  output logic                                   heap_we,
  output logic [$clog2(DEPTH)-1:0]               heap_waddr,
  output logic [ihq_pkg::ID_BITS+KEY_BITS-1:0]   heap_wdata,
  output logic                                   heap_re,
  output logic [$clog2(DEPTH)-1:0]               heap_raddr,
  input  logic [ihq_pkg::ID_BITS+KEY_BITS-1:0]   heap_rdata,
  output logic                                   pos_we,
  output logic [$clog2(DEPTH)-1:0]               pos_waddr,
  output logic [$clog2(DEPTH+1)-1:0]             pos_wdata,
  output logic                                   pos_re,
  output logic [$clog2(DEPTH)-1:0]               pos_raddr,
  input  logic [$clog2(DEPTH+1)-1:0]             pos_rdata
);
  import ihq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int KB = KEY_BITS;

  state_t state, state_next;
  logic [SW-1:0] s, s_next;
  logic [SW-1:0] count, count_next;
  logic [ID_BITS-1:0] cur_id, cur_id_next;
  logic [KB-1:0] cur_key, cur_key_next;
  logic bst_child, bst_child_next;
  logic [SW-1:0] bst_slot, bst_slot_next;
  logic [ID_BITS-1:0] bst_id, bst_id_next;
  logic [KB-1:0] bst_key, bst_key_next;
  logic [ID_BITS-1:0] op_id, op_id_next;
  logic [KB-1:0] op_key, op_key_next;
  status_t st, st_next;
  logic [ID_BITS-1:0] pid, pid_next;
  logic [KB-1:0] pkey, pkey_next;
  logic [AW-1:0] clr, clr_next;
  logic res_valid_next;
  res_word_t res_next;

  logic [SW:0] lc, rc, lc_m1;
  logic [SW-1:0] s_m1, p_m1, cnt_m1, ps_m1, cap_eff;
  logic [31:0] cmd_id_ext, cur_id_ext, rd_id_ext, bst_id_ext;
  logic [ID_BITS-1:0] rd_id;
  logic [KB-1:0] rd_key, cmp_key, cmd_key;
  logic cmd_id_big;

  assign lc         = {s, 1'b0};
  assign rc         = lc + (SW+1)'(1);
  assign lc_m1      = lc - (SW+1)'(1);
  assign s_m1       = s - SW'(1);
  assign p_m1       = (s >> 1) - SW'(1);
  assign cnt_m1     = count - SW'(1);
  assign ps_m1      = pos_rdata - SW'(1);
  assign rd_id      = heap_rdata[ID_BITS+KB-1:KB];
  assign rd_key     = heap_rdata[KB-1:0];
  assign cmd_key    = KB'(cmd.new_key);
  assign cmd_id_ext = 32'(cmd.item_id);
  assign cur_id_ext = 32'(cur_id);
  assign rd_id_ext  = 32'(rd_id);
  assign bst_id_ext = 32'(bst_id);
  assign cmd_id_big = cmd_id_ext >= 32'(DEPTH);
  assign cmp_key    = bst_child ? bst_key : cur_key;

  // zero behaves as one, anything above the built depth as the depth
  assign cap_eff = (capacity == '0) ? SW'(1) :
                   ((32'(capacity) > 32'(DEPTH)) ? SW'(DEPTH) : SW'(capacity));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
    s         <= s_next;
    cur_id    <= cur_id_next;
    cur_key   <= cur_key_next;
    bst_child <= bst_child_next;
    bst_slot  <= bst_slot_next;
    bst_id    <= bst_id_next;
    bst_key   <= bst_key_next;
    op_id     <= op_id_next;
    op_key    <= op_key_next;
    st        <= st_next;
    pid       <= pid_next;
    pkey      <= pkey_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    count_next     = count;
    s_next         = s;
    cur_id_next    = cur_id;
    cur_key_next   = cur_key;
    bst_child_next = bst_child;
    bst_slot_next  = bst_slot;
    bst_id_next    = bst_id;
    bst_key_next   = bst_key;
    op_id_next     = op_id;
    op_key_next    = op_key;
    st_next        = st;
    pid_next       = pid;
    pkey_next      = pkey;
    res_next       = res;
    res_valid_next = res_valid && res_stall;
    cmd_stall      = (state != S_IDLE);
    heap_we        = 1'b0;
    heap_waddr     = s_m1[AW-1:0];
    heap_wdata     = {cur_id, cur_key};
    heap_re        = 1'b0;
    heap_raddr     = '0;
    pos_we         = 1'b0;
    pos_waddr      = cur_id_ext[AW-1:0];
    pos_wdata      = s;
    pos_re         = 1'b0;
    pos_raddr      = cmd_id_ext[AW-1:0];

    case (state)
      S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr;
        pos_wdata = '0;
        clr_next  = clr + AW'(1);
        if (clr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          op_id_next  = cmd.item_id;
          op_key_next = cmd_key;
          st_next     = ST_OK;
          pid_next    = '0;
          pkey_next   = '0;
          case (cmd.action)
            ACT_PUSH: begin
              if (count >= cap_eff) begin
                st_next    = ST_FULL;
                state_next = S_DONE;
              end else if (cmd_id_big) begin
                st_next    = ST_ABSENT;
                state_next = S_DONE;
              end else begin
                pos_re     = 1'b1;
                state_next = S_PUSH_CHK;
              end
            end
            ACT_POP: begin
              if (count == '0) begin
                st_next    = ST_EMPTY;
                state_next = S_DONE;
              end else begin
                heap_re    = 1'b1;
                heap_raddr = '0;
                state_next = S_POP_ROOT;
              end
            end
            ACT_INCREASE: begin
              if (cmd_id_big) begin
                st_next    = ST_ABSENT;
                state_next = S_DONE;
              end else begin
                pos_re     = 1'b1;
                state_next = S_INC_POS;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_PUSH_CHK: begin
        if (pos_rdata != '0) begin
          st_next    = ST_DUP;
          state_next = S_DONE;
        end else begin
          count_next   = count + SW'(1);
          s_next       = count + SW'(1);
          cur_id_next  = op_id;
          cur_key_next = op_key;
          state_next   = S_UP;
        end
      end
      S_UP: begin
        if (s == SW'(1)) begin
          heap_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = p_m1[AW-1:0];
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (cur_key < rd_key) begin
          // parent drops into the hole
          heap_wdata = heap_rdata;
          pos_waddr  = rd_id_ext[AW-1:0];
          s_next     = s >> 1;
          state_next = S_UP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP_ROOT: begin
        pid_next   = rd_id;
        pkey_next  = rd_key;
        pos_we     = 1'b1;
        pos_waddr  = rd_id_ext[AW-1:0];
        pos_wdata  = '0;
        heap_re    = 1'b1;
        heap_raddr = cnt_m1[AW-1:0];
        state_next = S_POP_LAST;
      end
      S_POP_LAST: begin
        count_next = count - SW'(1);
        if (count == SW'(1)) begin
          state_next = S_DONE;
        end else begin
          cur_id_next  = rd_id;
          cur_key_next = rd_key;
          s_next       = SW'(1);
          state_next   = S_DOWN;
        end
      end
      S_DOWN: begin
        if (lc > {1'b0, count}) begin
          heap_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = lc_m1[AW-1:0];
          state_next = S_DOWN_L;
        end
      end
      S_DOWN_L: begin
        bst_child_next = rd_key < cur_key;
        bst_slot_next  = lc[SW-1:0];
        bst_id_next    = rd_id;
        bst_key_next   = rd_key;
        if (rc <= {1'b0, count}) begin
          heap_re    = 1'b1;
          heap_raddr = lc[AW-1:0];
          state_next = S_DOWN_R;
        end else begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
          if (rd_key < cur_key) begin
            heap_wdata = heap_rdata;
            pos_waddr  = rd_id_ext[AW-1:0];
            s_next     = lc[SW-1:0];
            state_next = S_DOWN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DOWN_R: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        // left wins ties, so the right child must be strictly smaller
        if (rd_key < cmp_key) begin
          heap_wdata = heap_rdata;
          pos_waddr  = rd_id_ext[AW-1:0];
          s_next     = rc[SW-1:0];
          state_next = S_DOWN;
        end else if (bst_child) begin
          heap_wdata = {bst_id, bst_key};
          pos_waddr  = bst_id_ext[AW-1:0];
          s_next     = bst_slot;
          state_next = S_DOWN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_INC_POS: begin
        if (pos_rdata == '0 || pos_rdata > count) begin
          st_next    = ST_ABSENT;
          state_next = S_DONE;
        end else begin
          s_next     = pos_rdata;
          heap_re    = 1'b1;
          heap_raddr = ps_m1[AW-1:0];
          state_next = S_INC_KEY;
        end
      end
      S_INC_KEY: begin
        if (op_key < rd_key) begin
          st_next    = ST_LOWER;
          state_next = S_DONE;
        end else begin
          cur_id_next  = rd_id;
          cur_key_next = op_key;
          state_next   = S_DOWN;
        end
      end
      S_DONE: begin
        if (!res_valid || !res_stall) begin
          res_valid_next       = 1'b1;
          res_next.status      = st;
          res_next.popped_id   = pid;
          res_next.popped_key  = KEY_IN_BITS'(pkey);
          res_next.entry_count = CAP_BITS'(count);
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/indexed_min_heap_queue_unit.sv */
// top level of the indexed min-heap queue: register port, memories and sequencer
//
// Keeps a binary min-heap of (id, key) words in one memory and an id-to-slot
// table in a second; one command word is processed at a time and yields one
// result word. Each heap level takes its turns on the shared heap read port
// (parent read then compare on push; left and right child reads on the way
// down), and the result is loaded into a result register. A command refused
// on its fields or on the entry count, and a no-op, goes straight to the
// result; a duplicate push or an unknown id on key increase is found in the
// id table, and a lower key in the heap memory. While a result word waits on
// a stall the next command is still taken, but its result is held back until
// the waiting word is taken. After reset the id table is swept to zero, one
// entry per cycle, before the first command word is taken; capacity writes
// are accepted during that sweep.
`default_nettype none
module indexed_min_heap_queue_unit #(
  parameter int DEPTH    = ihq_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ihq_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  ihq_pkg::cmd_word_t             cmd,
  output logic                           res_valid,
  input  logic                           res_stall,
  output ihq_pkg::res_word_t             res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ihq_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ihq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int HW = ID_BITS + KEY_BITS;

  logic [CAP_BITS-1:0] capacity;

  logic heap_we, heap_re, pos_we, pos_re;
  logic [AW-1:0] heap_waddr, heap_raddr, pos_waddr, pos_raddr;
  logic [HW-1:0] heap_wdata, heap_rdata;
  logic [SW-1:0] pos_wdata, pos_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_BITS-1:0];
    end
  end

  ihq_ram #(.WIDTH(HW), .ADDRS(DEPTH)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .re    (heap_re),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  ihq_ram #(.WIDTH(SW), .ADDRS(DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  ihq_ctrl #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .heap_we    (heap_we),
    .heap_waddr (heap_waddr),
    .heap_wdata (heap_wdata),
    .heap_re    (heap_re),
    .heap_raddr (heap_raddr),
    .heap_rdata (heap_rdata),
    .pos_we     (pos_we),
    .pos_waddr  (pos_waddr),
    .pos_wdata  (pos_wdata),
    .pos_re     (pos_re),
    .pos_raddr  (pos_raddr),
    .pos_rdata  (pos_rdata)
  );

endmodule
`default_nettype wire

/* src/ihq_checker.sv */
// port-level checks of the indexed min-heap queue and their bind
`default_nettype none
module ihq_checker #(
  parameter int DEPTH = ihq_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input ihq_pkg::cmd_word_t cmd,
  input logic               res_valid,
  input logic               res_stall,
  input ihq_pkg::res_word_t res
);
  import ihq_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result word changed");

  a_pop_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.popped_id == '0 && res.popped_key == '0)
    else $error("popped fields set on a failed operation");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.entry_count <= DEPTH)
    else $error("entry count above depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_EMPTY |-> res.entry_count == '0)
    else $error("empty status with entries queued");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FULL |-> res.entry_count != '0)
    else $error("full status with no entries");

endmodule

bind indexed_min_heap_queue_unit ihq_checker #(.DEPTH(DEPTH)) u_ihq_checker (.*);
`default_nettype wire

/* dv/ihq_checker.sv */
// checker for the indexed min-heap queue: predicts each result word and compares
`default_nettype none
module ihq_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  ihq_pkg::cmd_word_t cmd,
  input  logic               res_valid,
  input  logic               res_stall,
  input  ihq_pkg::res_word_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ihq_pkg::*;

  localparam int DEPTH = 1024;

  logic [9:0]  heap_id [1:DEPTH];
  logic [31:0] heap_key [1:DEPTH];
  logic [10:0] slot_of [0:DEPTH-1];
  int          count;
  logic [10:0] cap_reg;
  res_word_t   expected_res [$];

  function automatic void swap_slots(int a, int b);
    logic [9:0]  ti;
    logic [31:0] tk;
    ti = heap_id[a]; tk = heap_key[a];
    heap_id[a] = heap_id[b]; heap_key[a] = heap_key[b];
    heap_id[b] = ti; heap_key[b] = tk;
    slot_of[heap_id[a]] = a[10:0];
    slot_of[heap_id[b]] = b[10:0];
  endfunction

  function automatic void sink_slot(int s);
    int l, r, best;
    forever begin
      l = 2 * s; r = l + 1; best = s;
      if (l <= count && heap_key[l] < heap_key[best]) best = l;
      if (r <= count && heap_key[r] < heap_key[best]) best = r;
      if (best == s) break;
      swap_slots(s, best);
      s = best;
    end
  endfunction

  function automatic res_word_t heap_apply(cmd_word_t c);
    res_word_t o;
    int cap, s;
    o = '0;
    o.status = ST_OK;
    cap = cap_reg;
    if (cap == 0) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    case (c.action)
      ACT_PUSH: begin
        if (count >= cap) o.status = ST_FULL;
        else if (slot_of[c.item_id] != 0) o.status = ST_DUP;
        else begin
          count++;
          s = count;
          heap_id[s] = c.item_id; heap_key[s] = c.new_key;
          slot_of[c.item_id] = s[10:0];
          while (s > 1 && heap_key[s] < heap_key[s/2]) begin
            swap_slots(s, s/2);
            s = s / 2;
          end
        end
      end
      ACT_POP: begin
        if (count == 0) o.status = ST_EMPTY;
        else begin
          o.popped_id = heap_id[1];
          o.popped_key = heap_key[1];
          slot_of[heap_id[1]] = '0;
          heap_id[1] = heap_id[count]; heap_key[1] = heap_key[count];
          count--;
          if (count > 0) begin
            slot_of[heap_id[1]] = 11'd1;
            sink_slot(1);
          end
        end
      end
      ACT_INCREASE: begin
        s = slot_of[c.item_id];
        if (s == 0 || s > count) o.status = ST_ABSENT;
        else if (c.new_key < heap_key[s]) o.status = ST_LOWER;
        else begin
          heap_key[s] = c.new_key;
          sink_slot(s);
        end
      end
      default: ;
    endcase
    o.entry_count = count[10:0];
    return o;
  endfunction

  always @(posedge clk) begin
    res_word_t e;
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) slot_of[k] = '0;
      count = 0;
      cap_reg = CAP_RESET;
      fail_count <= 0;
      expected_res.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        cap_reg = pwdata[10:0];
      if (cmd_valid && !cmd_stall) expected_res.push_back(heap_apply(cmd));
      if (res_valid && !res_stall) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, res);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_res.pop_front();
          if (e.status !== res.status || e.popped_id !== res.popped_id ||
              e.popped_key !== res.popped_key || e.entry_count !== res.entry_count) begin
            $display("%0t: mismatch expected st=%0d id=%0d key=%h n=%0d",
                     $time, e.status, e.popped_id, e.popped_key, e.entry_count);
            $display("%0t:          actual   st=%0d id=%0d key=%h n=%0d",
                     $time, res.status, res.popped_id, res.popped_key, res.entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_res.size();
  end
endmodule
`default_nettype wire

/* dv/tb_indexed_min_heap_queue_unit.sv */
// testbench top of the indexed min-heap queue: stimulus and verdict
`default_nettype none
module tb_indexed_min_heap_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ihq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_word_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  bit quiet = 1'b0;
  bit keys_low = 1'b0;

  always #4 clk = ~clk;

  indexed_min_heap_queue_unit u_top (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .res_valid, .res_stall, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ihq_scoreboard u_chk (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .res_valid, .res_stall, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  // receiver stalls in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  task automatic write_capacity(input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_word(input action_t a, input logic [9:0] id, input logic [31:0] k);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd.action <= a; cmd.item_id <= id; cmd.new_key <= k;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return keys_low ? $urandom_range(0, 63) : $urandom;
    endcase
  endfunction

  task automatic random_phase(input int n, input int id_span);
    int r;
    action_t a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) a = ACT_PUSH;
      else if (r < 75) a = ACT_POP;
      else if (r < 97) a = ACT_INCREASE;
      else a = ACT_NOP;
      keys_low = (i % 3) == 0;
      send_word(a, 10'($urandom_range(0, id_span)), rand_key());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: empty pop, ties, duplicate, absent, lower, equal, extremes
    send_word(ACT_POP, 10'd0, 32'd0);
    send_word(ACT_INCREASE, 10'd5, 32'd1);
    send_word(ACT_PUSH, 10'd1023, 32'hFFFF_FFFF);
    send_word(ACT_PUSH, 10'd0, 32'd0);
    send_word(ACT_PUSH, 10'd7, 32'd100);
    send_word(ACT_PUSH, 10'd8, 32'd100);
    send_word(ACT_PUSH, 10'd9, 32'd100);
    send_word(ACT_PUSH, 10'd7, 32'd3);
    send_word(ACT_INCREASE, 10'd7, 32'd50);
    send_word(ACT_INCREASE, 10'd8, 32'd100);
    send_word(ACT_INCREASE, 10'd0, 32'd200);
    send_word(ACT_NOP, 10'd3, 32'd0);
    send_word(ACT_INCREASE, 10'd1023, 32'hFFFF_FFFF);
    repeat (6) send_word(ACT_POP, 10'd0, 32'd0);
    drain_results();
    // capacity one and zero
    write_capacity(32'd1);
    send_word(ACT_PUSH, 10'd2, 32'd5);
    send_word(ACT_PUSH, 10'd3, 32'd6);
    drain_results();
    write_capacity(32'd0);
    send_word(ACT_PUSH, 10'd4, 32'd1);
    send_word(ACT_POP, 10'd0, 32'd0);
    send_word(ACT_PUSH, 10'd4, 32'd1);
    drain_results();
    write_capacity(32'd2047);
    random_phase(300, 1023);
    drain_results();
    write_capacity(32'd5);
    random_phase(300, 15);
    drain_results();
    write_capacity(32'd40);
    random_phase(500, 63);
    drain_results();
    write_capacity(32'd1024);
    random_phase(500, 1023);
    quiet = 1'b1;
    random_phase(200, 31);
    drain_results();
    if (fail_count == 0) $display("indexed_min_heap_queue_unit verification clean");
    else $display("indexed_min_heap_queue_unit verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("indexed_min_heap_queue_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
